### hw/rtl/quartic_root_bracket_newton_top_assert.svh
// Assertion macros for the quartic root finder
`ifndef QUARTIC_ROOT_BRACKET_NEWTON_TOP_ASSERT_SVH
`define QUARTIC_ROOT_BRACKET_NEWTON_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define QRB_ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define QRB_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define QRB_ASSERT_IMPL(label, clk, rst_n, prop)
`define QRB_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

### hw/rtl/qrbn_pkg.sv
`timescale 1ns / 1ps
package qrbn_pkg;
  localparam int MAX_POINTS_DEF = 512;
  localparam int MAX_ITER_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;
  localparam int WW = 48;
  localparam int MAX_BRK = 4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ITER = 2'd1;
  localparam logic [1:0] ST_ZDER = 2'd2;
  localparam logic [1:0] ST_TRUNC = 2'd3;

  // Datapath operation selects
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_EVAL_SCAN,
    OP_EVAL_NEWT,
    OP_DERIV,
    OP_DIV,
    OP_STEP
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_W,
    S_NSTART,
    S_NEVAL,
    S_NEVAL_W,
    S_NCHECK,
    S_DER_W,
    S_DIV_W,
    S_EMIT,
    S_NONE_EMIT
  } state_t;

  typedef struct packed {
    op_t        op;
    logic       next_point;
    logic       sel_brk;
  } cmd_t;

  typedef struct packed {
    logic       busy;
    logic       scan_done;
    logic       conv;
    logic       zero_der;
    logic       nb_zero;
  } stat_t;

  function automatic logic signed [WW-1:0] sat_w(input logic signed [WW+2:0] v);
    logic signed [WW+2:0] lim;
    lim = (WW+3)'(64'sd1 <<< 39);
    if (v > lim) sat_w = WW'(lim);
    else if (v < -lim) sat_w = WW'(-lim);
    else sat_w = WW'(v);
  endfunction

  function automatic logic signed [WW-1:0] qk(input int n, input int fb);
    longint t;
    t = ((longint'(n) <<< fb) + 50) / 100;
    qk = WW'(t);
  endfunction
endpackage

### hw/rtl/qrbn_datapath.sv
`timescale 1ns / 1ps
`include "quartic_root_bracket_newton_top_assert.svh"
module qrbn_datapath #(
  parameter int MAX_POINTS = qrbn_pkg::MAX_POINTS_DEF,
  parameter int MAX_ITER = qrbn_pkg::MAX_ITER_DEF,
  parameter int FRAC_BITS = qrbn_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  qrbn_pkg::cmd_t      cmd,
  output qrbn_pkg::stat_t     stat,
  input  logic signed [23:0]  lo_i,
  input  logic signed [23:0]  hi_i,
  input  logic [22:0]         step_i,
  input  logic [22:0]         tol_i,
  output logic signed [23:0]  root_o,
  output logic [6:0]          iter_o,
  output logic [1:0]          num_o,
  output logic [1:0]          st_o,
  output logic                last_o
);
  localparam int WW = qrbn_pkg::WW;
  localparam int PW = $clog2(MAX_POINTS + 1);
  localparam int DB = 40 + FRAC_BITS;

  // Request registers
  logic signed [25:0] xp_r, xp_nxt;
  logic signed [23:0] hi_r, x_r, x_nxt;
  logic [22:0] step_r, tol_r;
  logic [PW-1:0] cnt_r, cnt_nxt;
  logic trunc_r, trunc_nxt, havep_r, havep_nxt, prevs_r, prevs_nxt;
  logic prevz_r, prevz_nxt;
  logic signed [23:0] brk_r [qrbn_pkg::MAX_BRK];
  logic [2:0] nb_r, nb_nxt;
  logic [1:0] k_r, k_nxt;
  logic [6:0] it_r, it_nxt;

  // Horner evaluator: one multiply a cycle
  logic [1:0] hstep_r, hstep_nxt;
  logic hbusy_r, hbusy_nxt, hder_r, hder_nxt, hscan_r, hscan_nxt;
  logic signed [WW-1:0] h_r, h_nxt, pv_r, pv_nxt, d_r, d_nxt;
  logic signed [23:0] hx_r, hx_nxt;
  logic signed [WW+24:0] prod;
  logic signed [WW+2:0] mq;
  logic signed [WW-1:0] mqs, addc;

  // Divider: restoring, one bit a cycle
  logic [DB-1:0] dq_r, dq_nxt;
  logic [41:0] drem_r, drem_nxt;
  logic [39:0] dden_r, dden_nxt;
  logic dneg_r, dneg_nxt, dbusy_r, dbusy_nxt;
  logic [6:0] dcnt_r, dcnt_nxt;
  logic [41:0] dtry;

  logic signed [WW-1:0] num_sat;
  logic signed [DB:0] xnew;
  logic signed [DB:0] qs;
  logic signed [WW-1:0] tol_s;
  logic psign, pzero, brk_hit;
  logic signed [PW+24:0] lim_chk;

  function automatic logic signed [WW-1:0] sat_in(input logic signed [WW-1:0] v);
    sat_in = qrbn_pkg::sat_w((WW+3)'(v));
  endfunction

  assign prod = h_r * hx_r;
  assign mq = (WW+3)'(prod >>> FRAC_BITS);
  assign mqs = qrbn_pkg::sat_w(mq);
  always_comb begin
    unique case ({hder_r, hstep_r})
      3'b000: addc = qrbn_pkg::qk(1491, FRAC_BITS);
      3'b001: addc = qrbn_pkg::qk(954, FRAC_BITS);
      3'b010: addc = -qrbn_pkg::qk(2592, FRAC_BITS);
      3'b100: addc = qrbn_pkg::qk(2982, FRAC_BITS);
      3'b101: addc = qrbn_pkg::qk(954, FRAC_BITS);
      default: addc = '0;
    endcase
  end

  always_comb begin
    num_sat = pv_r;
    if (pv_r > (WW'(64'sd1 <<< 38))) num_sat = WW'(64'sd1 <<< 38);
    if (pv_r < -(WW'(64'sd1 <<< 38))) num_sat = -(WW'(64'sd1 <<< 38));
    dtry = {drem_r[40:0], dq_r[DB-1]} - {2'b0, dden_r};
    qs = dneg_r ? -$signed({1'b0, dq_r}) : $signed({1'b0, dq_r});
    xnew = (DB+1)'(x_r) - qs;
    psign = h_nxt[WW-1];
    pzero = (h_nxt == '0);
    lim_chk = (PW+25)'(lo_i) +
              $signed({1'b0, PW'(MAX_POINTS)}) * $signed({1'b0, step_i});
  end

  always_comb begin
    xp_nxt = xp_r; x_nxt = x_r; cnt_nxt = cnt_r; trunc_nxt = trunc_r;
    havep_nxt = havep_r; prevs_nxt = prevs_r; prevz_nxt = prevz_r;
    nb_nxt = nb_r; k_nxt = k_r; it_nxt = it_r;
    hstep_nxt = hstep_r; hbusy_nxt = hbusy_r; hder_nxt = hder_r; hscan_nxt = hscan_r;
    h_nxt = h_r; hx_nxt = hx_r; pv_nxt = pv_r; d_nxt = d_r;
    dq_nxt = dq_r; drem_nxt = drem_r; dden_nxt = dden_r; dneg_nxt = dneg_r;
    dbusy_nxt = dbusy_r; dcnt_nxt = dcnt_r; brk_hit = 1'b0;
    unique case (cmd.op)
      qrbn_pkg::OP_LOAD: begin
        xp_nxt = 26'(lo_i); cnt_nxt = '0; nb_nxt = '0; havep_nxt = 1'b0;
        prevz_nxt = 1'b0; prevs_nxt = 1'b0; k_nxt = '0;
        trunc_nxt = (lim_chk <= (PW+25)'(hi_i));
      end
      qrbn_pkg::OP_EVAL_SCAN: begin
        hx_nxt = 24'(xp_r); h_nxt = sat_in(WW'(xp_r) - qrbn_pkg::qk(800, FRAC_BITS));
        hstep_nxt = '0; hbusy_nxt = 1'b1; hder_nxt = 1'b0; hscan_nxt = 1'b1;
      end
      qrbn_pkg::OP_EVAL_NEWT: begin
        if (cmd.sel_brk) begin
          x_nxt = brk_r[k_r]; it_nxt = '0;
          hx_nxt = brk_r[k_r];
          h_nxt = sat_in(WW'(brk_r[k_r]) - qrbn_pkg::qk(800, FRAC_BITS));
        end else begin
          hx_nxt = x_r; h_nxt = sat_in(WW'(x_r) - qrbn_pkg::qk(800, FRAC_BITS));
        end
        hstep_nxt = '0; hbusy_nxt = 1'b1; hder_nxt = 1'b0; hscan_nxt = 1'b0;
      end
      qrbn_pkg::OP_DERIV: begin
        hx_nxt = x_r;
        h_nxt = sat_in((WW'(x_r) <<< 2) - qrbn_pkg::qk(2400, FRAC_BITS));
        hstep_nxt = '0; hbusy_nxt = 1'b1; hder_nxt = 1'b1; hscan_nxt = 1'b0;
      end
      qrbn_pkg::OP_DIV: begin
        dneg_nxt = num_sat[WW-1] ^ d_r[WW-1];
        dq_nxt = DB'(num_sat[WW-1] ? -num_sat : num_sat) << FRAC_BITS;
        dden_nxt = 40'(d_r[WW-1] ? -d_r : d_r);
        drem_nxt = '0; dcnt_nxt = 7'(DB); dbusy_nxt = 1'b1;
      end
      qrbn_pkg::OP_STEP: begin
        if (xnew > (DB+1)'(24'sh7fffff)) x_nxt = 24'sh7fffff;
        else if (xnew < -(DB+1)'(25'sd8388608)) x_nxt = 24'sh800000;
        else x_nxt = 24'(xnew);
        it_nxt = it_r + 7'd1;
      end
      default: ;
    endcase
    if (cmd.next_point) k_nxt = k_r + 2'd1;
    // Run one Horner stage
    if (hbusy_r) begin
      h_nxt = qrbn_pkg::sat_w((WW+3)'(mqs) + (WW+3)'(addc));
      hstep_nxt = hstep_r + 2'd1;
      if ((hder_r && hstep_r == 2'd1) || (!hder_r && hstep_r == 2'd2)) begin
        hbusy_nxt = 1'b0;
        if (hder_r) d_nxt = h_nxt; else pv_nxt = h_nxt;
        if (hscan_r) begin
          if (havep_r && !prevz_r && !pzero && (prevs_r != psign) &&
              nb_r < 3'(qrbn_pkg::MAX_BRK)) brk_hit = 1'b1;
          if (brk_hit) nb_nxt = nb_r + 3'd1;
          havep_nxt = 1'b1; prevs_nxt = psign; prevz_nxt = pzero;
          xp_nxt = xp_r + 26'($signed({1'b0, step_r}));
          cnt_nxt = cnt_r + PW'(1);
        end
      end
    end
    // Run one divider bit
    if (dbusy_r) begin
      if (!dtry[41]) begin
        drem_nxt = dtry; dq_nxt = {dq_r[DB-2:0], 1'b1};
      end else begin
        drem_nxt = {drem_r[40:0], dq_r[DB-1]}; dq_nxt = {dq_r[DB-2:0], 1'b0};
      end
      dcnt_nxt = dcnt_r - 7'd1;
      if (dcnt_r == 7'd1) dbusy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hbusy_r <= 1'b0; dbusy_r <= 1'b0;
      nb_r <= '0; k_r <= '0; it_r <= '0;
    end else begin
      hbusy_r <= hbusy_nxt; dbusy_r <= dbusy_nxt;
      nb_r <= nb_nxt; k_r <= k_nxt; it_r <= it_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == qrbn_pkg::OP_LOAD) begin
      hi_r <= hi_i; step_r <= step_i; tol_r <= tol_i;
    end
    if (brk_hit) brk_r[nb_r[1:0]] <= 24'(xp_r);
    xp_r <= xp_nxt; x_r <= x_nxt; cnt_r <= cnt_nxt; trunc_r <= trunc_nxt;
    havep_r <= havep_nxt; prevs_r <= prevs_nxt; prevz_r <= prevz_nxt;
    hstep_r <= hstep_nxt; hder_r <= hder_nxt; hscan_r <= hscan_nxt;
    h_r <= h_nxt; hx_r <= hx_nxt; pv_r <= pv_nxt; d_r <= d_nxt;
    dq_r <= dq_nxt; drem_r <= drem_nxt; dden_r <= dden_nxt; dneg_r <= dneg_nxt;
    dcnt_r <= dcnt_nxt;
  end

  // Status toward the controller
  assign tol_s = WW'($signed({1'b0, tol_r}));
  always_comb begin
    stat.busy = hbusy_r | dbusy_r;
    stat.scan_done = (cnt_r == PW'(MAX_POINTS)) || (xp_r > 26'(hi_r));
    stat.conv = (pv_r <= tol_s) && (pv_r >= -tol_s);
    stat.zero_der = (d_r == '0);
    stat.nb_zero = (nb_r == '0);
  end

  assign root_o = stat.nb_zero ? '0 : x_r;
  assign iter_o = stat.nb_zero ? '0 : it_r;
  assign num_o = stat.nb_zero ? '0 : k_r;
  assign last_o = stat.nb_zero || (3'(k_r) + 3'd1 == nb_r);
  logic [1:0] nst;
  assign nst = (it_r >= 7'(MAX_ITER) && !stat.conv) ? qrbn_pkg::ST_ITER :
               (!stat.conv) ? qrbn_pkg::ST_ZDER : qrbn_pkg::ST_OK;
  assign st_o = stat.nb_zero ? (trunc_r ? qrbn_pkg::ST_TRUNC : qrbn_pkg::ST_OK) :
                ((nst == qrbn_pkg::ST_OK && trunc_r) ? qrbn_pkg::ST_TRUNC : nst);

  `QRB_ASSERT_IMPL(a_nb_max, clk, rst_n, nb_r <= 3'(qrbn_pkg::MAX_BRK))
  `QRB_ASSERT_IMPL(a_one_unit, clk, rst_n, !(hbusy_r && dbusy_r))
  `QRB_ASSERT_NEXT(a_iter_cap, clk, rst_n, 1'b1, it_r <= 7'(MAX_ITER))
endmodule

### hw/rtl/qrbn_ctrl.sv
`timescale 1ns / 1ps
`include "quartic_root_bracket_newton_top_assert.svh"
module qrbn_ctrl #(
  parameter int MAX_ITER = qrbn_pkg::MAX_ITER_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  logic            last_i,
  input  logic [6:0]      iter_i,
  input  qrbn_pkg::stat_t stat,
  output qrbn_pkg::cmd_t  cmd
);
  qrbn_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= qrbn_pkg::S_IDLE;
    else state_r <= state_nxt;
  end

  // Sequence scan, Newton loop and result hand-off
  always_comb begin
    state_nxt = state_r;
    cmd = '{op: qrbn_pkg::OP_NONE, next_point: 1'b0, sel_brk: 1'b0};
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      qrbn_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op = qrbn_pkg::OP_LOAD;
          state_nxt = qrbn_pkg::S_SCAN;
        end
      end
      qrbn_pkg::S_SCAN: begin
        if (stat.scan_done) begin
          state_nxt = stat.nb_zero ? qrbn_pkg::S_NONE_EMIT : qrbn_pkg::S_NSTART;
        end else begin
          cmd.op = qrbn_pkg::OP_EVAL_SCAN; state_nxt = qrbn_pkg::S_SCAN_W;
        end
      end
      qrbn_pkg::S_SCAN_W: if (!stat.busy) state_nxt = qrbn_pkg::S_SCAN;
      qrbn_pkg::S_NSTART: begin
        cmd.op = qrbn_pkg::OP_EVAL_NEWT; cmd.sel_brk = 1'b1;
        state_nxt = qrbn_pkg::S_NEVAL_W;
      end
      // Evaluate p at the stepped x
      qrbn_pkg::S_NEVAL: begin
        cmd.op = qrbn_pkg::OP_EVAL_NEWT;
        state_nxt = qrbn_pkg::S_NEVAL_W;
      end
      qrbn_pkg::S_NEVAL_W: if (!stat.busy) state_nxt = qrbn_pkg::S_NCHECK;
      qrbn_pkg::S_NCHECK: begin
        if (stat.conv || iter_i >= 7'(MAX_ITER)) state_nxt = qrbn_pkg::S_EMIT;
        else begin
          cmd.op = qrbn_pkg::OP_DERIV; state_nxt = qrbn_pkg::S_DER_W;
        end
      end
      qrbn_pkg::S_DER_W: begin
        if (!stat.busy) begin
          if (stat.zero_der) state_nxt = qrbn_pkg::S_EMIT;
          else begin
            cmd.op = qrbn_pkg::OP_DIV; state_nxt = qrbn_pkg::S_DIV_W;
          end
        end
      end
      qrbn_pkg::S_DIV_W: begin
        if (!stat.busy) begin
          cmd.op = qrbn_pkg::OP_STEP; state_nxt = qrbn_pkg::S_NEVAL;
        end
      end
      qrbn_pkg::S_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (last_i) state_nxt = qrbn_pkg::S_IDLE;
          else begin
            cmd.next_point = 1'b1; state_nxt = qrbn_pkg::S_NSTART;
          end
        end
      end
      qrbn_pkg::S_NONE_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) state_nxt = qrbn_pkg::S_IDLE;
      end
      default: state_nxt = qrbn_pkg::S_IDLE;
    endcase
  end

  `QRB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `QRB_ASSERT_IMPL(a_no_take_busy, clk, rst_n, !(out_valid && !in_stall))
  `QRB_ASSERT_NEXT(a_load_scan, clk, rst_n, in_valid && !in_stall,
                   state_r == qrbn_pkg::S_SCAN)
endmodule

### hw/rtl/quartic_root_bracket_newton_top.sv
`timescale 1ns / 1ps
// Quartic root finder: scans p(x) on a grid, brackets sign changes and
// refines each with Newton steps.
// Input channel: in_valid/in_stall with lower/upper limit, step, tolerance.
// Result channel: out_valid/out_stall, one item per root (up to four) or a
// single no-root item; out_last_result marks the final item of a request.
// Each scan point is issued, run through the three-stage Horner evaluator
// and handed back; p is then evaluated at each bracket start, and each
// Newton step is a check, p' on the Horner evaluator, a division on the
// one-bit-a-cycle divider and p at the new x. The run time of a request
// is data dependent.
// One request is in flight at a time; in_stall stays high until its last
// result is taken. Results hold while out_stall is high.
// Reset (synchronous, rst_n low) returns the controller to idle and drops
// any request in progress.
module quartic_root_bracket_newton_top #(
  parameter int MAX_POINTS = qrbn_pkg::MAX_POINTS_DEF,
  parameter int MAX_ITER = qrbn_pkg::MAX_ITER_DEF,
  parameter int FRAC_BITS = qrbn_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] in_lower_limit,
  input  logic signed [23:0] in_upper_limit,
  input  logic [22:0]        in_grid_step,
  input  logic [22:0]        in_tolerance,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_root_value,
  output logic [6:0]         out_iteration_count,
  output logic [1:0]         out_root_number,
  output logic               out_root_found,
  output logic [1:0]         out_status_code,
  output logic               out_last_result
);
  qrbn_pkg::cmd_t  cmd;
  qrbn_pkg::stat_t stat;

  qrbn_datapath #(.MAX_POINTS(MAX_POINTS), .MAX_ITER(MAX_ITER), .FRAC_BITS(FRAC_BITS))
  u_dp (
    .clk, .rst_n, .cmd, .stat,
    .lo_i(in_lower_limit), .hi_i(in_upper_limit),
    .step_i(in_grid_step), .tol_i(in_tolerance),
    .root_o(out_root_value), .iter_o(out_iteration_count),
    .num_o(out_root_number), .st_o(out_status_code), .last_o(out_last_result)
  );

  qrbn_ctrl #(.MAX_ITER(MAX_ITER)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .last_i(out_last_result), .iter_i(out_iteration_count), .stat, .cmd
  );

  assign out_root_found = !stat.nb_zero;
endmodule

### bench/tb.sv
`timescale 1ns / 1ps
module tb;
  localparam longint ONE_Q = 64'sd1 << 16;
  localparam longint WIDE_SAT = 64'sd1 << 39;
  localparam longint NUM_SAT = 64'sd1 << 38;
  localparam longint XHI = 64'sd8388607;
  localparam longint XLO = -64'sd8388608;
  localparam int SCAN_POINTS = 512;
  localparam int ITER_CAP = 64;

  typedef struct {
    logic signed [23:0] root;
    logic [6:0]         iters;
    logic [1:0]         index;
    logic               found;
    logic [1:0]         status;
    logic               last;
  } root_res_t;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic signed [23:0] in_lower_limit = '0;
  logic signed [23:0] in_upper_limit = '0;
  logic [22:0]        in_grid_step = 23'd1;
  logic [22:0]        in_tolerance = 23'd1;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [23:0] out_root_value;
  logic [6:0]         out_iteration_count;
  logic [1:0]         out_root_number;
  logic               out_root_found;
  logic [1:0]         out_status_code;
  logic               out_last_result;

  root_res_t pending_roots[$];
  int err_count = 0;
  int hold_cycles = 0;
  int stall_burst = 0;
  bit quiet = 0;
  bit sender_gaps = 1;

  quartic_root_bracket_newton_top dut (.*);

  always #5 clk = ~clk;

  // Fixed-point helpers
  function automatic longint clampv(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint qconst(longint n);
    return (n * ONE_Q + 50) / 100;
  endfunction

  function automatic longint fx_mul(longint a, longint x);
    longint prod;
    prod = clampv(a, WIDE_SAT) * x;
    return clampv(prod >>> 16, WIDE_SAT);
  endfunction

  function automatic longint quartic_at(longint x);
    longint h;
    h = clampv(x - qconst(800), WIDE_SAT);
    h = clampv(fx_mul(h, x) + qconst(1491), WIDE_SAT);
    h = clampv(fx_mul(h, x) + qconst(954), WIDE_SAT);
    h = clampv(fx_mul(h, x) - qconst(2592), WIDE_SAT);
    return h;
  endfunction

  function automatic longint slope_at(longint x);
    longint h;
    h = clampv(4 * x - qconst(2400), WIDE_SAT);
    h = clampv(fx_mul(h, x) + qconst(2982), WIDE_SAT);
    h = clampv(fx_mul(h, x) + qconst(954), WIDE_SAT);
    return h;
  endfunction

  function automatic int sgn(longint v);
    return (v > 0) - (v < 0);
  endfunction

  // Scan the grid, bracket sign changes and refine each by Newton steps
  task automatic predict_roots(longint lo, longint hi, longint step, longint tol);
    longint brk[4];
    int nb;
    longint prev, xp, pv, x, d, q;
    bit have_prev, trunc;
    int iter;
    logic [1:0] st;
    root_res_t r;
    nb = 0;
    prev = 0;
    have_prev = 0;
    for (int i = 0; i < SCAN_POINTS; i++) begin
      xp = lo + longint'(i) * step;
      if (xp > hi) break;
      pv = quartic_at(xp);
      if (have_prev && sgn(prev) * sgn(pv) < 0 && nb < 4) begin
        brk[nb] = xp;
        nb++;
      end
      prev = pv;
      have_prev = 1;
    end
    trunc = (lo + longint'(SCAN_POINTS) * step) <= hi;
    if (nb == 0) begin
      r.root = '0;
      r.iters = '0;
      r.index = '0;
      r.found = 0;
      r.status = trunc ? qrbn_pkg::ST_TRUNC : qrbn_pkg::ST_OK;
      r.last = 1;
      pending_roots.push_back(r);
      return;
    end
    for (int k = 0; k < nb; k++) begin
      x = brk[k];
      pv = quartic_at(x);
      iter = 0;
      st = qrbn_pkg::ST_OK;
      while (pv > tol || pv < -tol) begin
        if (iter >= ITER_CAP) begin
          st = qrbn_pkg::ST_ITER;
          break;
        end
        d = slope_at(x);
        if (d == 0) begin
          st = qrbn_pkg::ST_ZDER;
          break;
        end
        q = clampv(pv, NUM_SAT) * ONE_Q / d;
        x = x - q;
        if (x > XHI) x = XHI;
        if (x < XLO) x = XLO;
        iter++;
        pv = quartic_at(x);
      end
      if (st == qrbn_pkg::ST_OK && trunc) st = qrbn_pkg::ST_TRUNC;
      r.root = x[23:0];
      r.iters = iter[6:0];
      r.index = k[1:0];
      r.found = 1;
      r.status = st;
      r.last = (k == nb - 1);
      pending_roots.push_back(r);
    end
  endtask

  task automatic report(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    err_count++;
  endtask

  // Drive one item, hold it until taken, then predict its roots
  task automatic send_item(longint lo, longint hi, longint step, longint tol);
    @(negedge clk);
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1;
    in_lower_limit <= lo[23:0];
    in_upper_limit <= hi[23:0];
    in_grid_step <= step[22:0];
    in_tolerance <= tol[22:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_roots(longint'($signed(lo[23:0])), longint'($signed(hi[23:0])),
                  longint'(step[22:0]), longint'(tol[22:0]));
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 0;
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    root_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_roots.size() == 0) begin
        report("unexpected result root_value", out_root_value, 0);
      end else begin
        e = pending_roots.pop_front();
        if (out_root_value !== e.root) report("root_value", out_root_value, e.root);
        if (out_iteration_count !== e.iters)
          report("iteration_count", out_iteration_count, e.iters);
        if (out_root_number !== e.index) report("root_number", out_root_number, e.index);
        if (out_root_found !== e.found) report("root_found", out_root_found, e.found);
        if (out_status_code !== e.status) report("status_code", out_status_code, e.status);
        if (out_last_result !== e.last) report("last_result", out_last_result, e.last);
      end
    end
  end

  // Receiver stalls: long hold-offs on request, short random bursts otherwise
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1;
      hold_cycles--;
    end else if (stall_burst > 0) begin
      out_stall <= 1;
      stall_burst--;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_stall <= 1;
      stall_burst = $urandom_range(0, 2);
    end else begin
      out_stall <= 0;
    end
  end

  function automatic longint rand_full24();
    return longint'($signed(24'($urandom())));
  endfunction

  // Field extremes, empty range, truncation, tight tolerance
  task automatic test_directed();
    send_item(XLO, XHI, 8388607, 8388607);
    send_item(XHI, XLO, 1, 1);
    send_item(0, 0, 1, 1);
    send_item(0, XHI, 1, 100);
    send_item(XLO, XHI, 1, 8388607);
    send_item(-3 * ONE_Q, 6 * ONE_Q, ONE_Q / 4, 1);
    send_item(-3 * ONE_Q, 6 * ONE_Q, ONE_Q / 4, 655);
    send_item(-3 * ONE_Q, 6 * ONE_Q, ONE_Q / 64, 65);
    send_item(-3 * ONE_Q, 6 * ONE_Q, 8388607, 8388607);
    send_item(-2 * ONE_Q, 0, 4096, 8388607);
    send_item(XLO, -XHI, 3, 2);
    send_item(XHI, XHI, 8388607, 1);
    send_item(5 * ONE_Q, 40 * ONE_Q, ONE_Q, 1);
    send_item(-40 * ONE_Q, -2 * ONE_Q, ONE_Q, 1);
    release_input();
  endtask

  // Mostly windows around the roots, some noise across the full fields
  task automatic test_random(int count);
    longint lo, span, step, tol;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 6) == 0) begin
        send_item(rand_full24(), rand_full24(), $urandom_range(1, 8388607),
                  $urandom_range(1, 8388607));
      end else begin
        lo = $urandom_range(0, 9 * ONE_Q) - 4 * ONE_Q;
        span = $urandom_range(0, 9 * ONE_Q);
        step = span / $urandom_range(2, 60) + 1;
        tol = $urandom_range(1, (1 << $urandom_range(1, 22)) - 1);
        send_item(lo, lo + span, step, tol);
      end
    end
    release_input();
  endtask

  // Hold the result side off for a long stretch while items keep coming
  task automatic test_backpressure();
    hold_cycles = 3000;
    for (int n = 0; n < 5; n++)
      send_item(-3 * ONE_Q, 6 * ONE_Q, ONE_Q / 8, 6553);
    release_input();
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    while (pending_roots.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    test_directed();
    test_random(60);
    test_backpressure();
    test_random(40);
    // last stretch runs without idling on either side
    @(negedge clk);
    quiet = 1;
    sender_gaps = 0;
    test_random(25);
    drain();
    if (pending_roots.size() != 0) begin
      $display("%0d expected results never arrived", pending_roots.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("tb NOT OK");
    $finish;
  end
endmodule
